@@ design/getm_pkg.sv @@
// Shared types, constants and register codes for the gradient edge threshold map.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package getm_pkg;

    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_CHANNEL_BITS = 8;

    localparam int LINE_WIDTH_W   = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int THRESH_W       = 17;
    localparam int ROW_W          = 12;
    localparam int MAX_HEIGHT     = 4096;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = THRESH_W;

    localparam logic [LINE_WIDTH_W-1:0]   RST_LINE_WIDTH   = 11'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [THRESH_W-1:0]       RST_THRESHOLD_SQ = 17'd4064;

    localparam int OUT_TDATA_W = 8;
    localparam int EDGE_BITS   = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINE_WIDTH        = 2'd0,
        CFG_FRAME_HEIGHT      = 2'd1,
        CFG_EDGE_THRESHOLD_SQ = 2'd2
    } t_cfg_index;

    typedef enum logic {
        BK_PRIMARY = 1'b0,
        BK_TRAILER = 1'b1
    } t_back_state;

    typedef struct packed {
        logic border;
        logic last_row;
        logic last_col;
    } t_item_flags;

endpackage

@@ design/getm_front.sv @@
// Front end: raster counters, the two line stores and the gradient squaring stage.
// Depends on getm_pkg.
`timescale 1ns / 1ps

module getm_front
    import getm_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [LINE_WIDTH_W-1:0]     i_line_width,
    input  logic [FRAME_HEIGHT_W-1:0]   i_frame_height,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [3*CHANNEL_BITS-1:0]   i_pixel,
    output logic                        o_push,
    input  logic                        i_queue_ready,
    output logic [12*CHANNEL_BITS-1:0]  o_squares,
    output t_item_flags                 o_flags
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int PW   = 3 * CHANNEL_BITS;
    localparam int SQW  = 2 * CHANNEL_BITS;
    localparam int CMPW = (LINE_WIDTH_W > AW + 1) ? LINE_WIDTH_W : AW + 1;

    logic [PW-1:0] r_upper_store  [MAX_WIDTH];
    logic [PW-1:0] r_center_store [MAX_WIDTH];

    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [AW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;

    logic             r_s1_valid;
    logic             r_s1_has_res;
    t_item_flags      r_s1_flags;
    logic [PW-1:0]    r_s1_cur;
    logic [PW-1:0]    r_s1_left;
    logic [PW-1:0]    r_left_next;
    logic [PW-1:0]    r_rd_upper;
    logic [PW-1:0]    r_rd_center;

    logic [AW:0]               col_inc;
    logic [CMPW-1:0]           lw_ext;
    logic [CMPW-1:0]           lw_lo;
    logic [FRAME_HEIGHT_W-1:0] row_inc;
    logic [FRAME_HEIGHT_W-1:0] h_lo;
    logic                      last_col;
    logic                      last_row;
    logic [AW-1:0]             rd_addr;
    logic                      accept;
    logic                      s1_leave;
    t_item_flags               flags_in;

    assign col_inc  = {1'b0, r_col} + 1'b1;
    assign lw_ext   = CMPW'(i_line_width);
    assign lw_lo    = (lw_ext < CMPW'(3)) ? CMPW'(3) : lw_ext;
    assign last_col = (CMPW'(col_inc) >= lw_lo) || (CMPW'(col_inc) >= CMPW'(MAX_WIDTH));

    assign row_inc  = {1'b0, r_row} + 1'b1;
    assign h_lo     = (i_frame_height < FRAME_HEIGHT_W'(3)) ? FRAME_HEIGHT_W'(3)
                                                            : i_frame_height;
    assign last_row = (row_inc >= h_lo) || (row_inc >= FRAME_HEIGHT_W'(MAX_HEIGHT));

    assign rd_addr = last_col ? '0 : col_inc[AW-1:0];

    assign s1_leave   = !r_s1_has_res || i_queue_ready;
    assign o_s_tready = !r_s1_valid || s1_leave;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_push     = r_s1_valid && r_s1_has_res;
    assign o_flags    = r_s1_flags;

    always_comb begin
        flags_in.border   = (r_row == ROW_W'(1)) || (r_col == '0) || last_col;
        flags_in.last_row = last_row;
        flags_in.last_col = last_col;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[AW-1:0];
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_s1_valid <= 1'b1;
            end else if (s1_leave) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_has_res <= (r_row != '0);
            r_s1_flags   <= flags_in;
            r_s1_cur     <= i_pixel;
            r_s1_left    <= r_left_next;
            r_left_next  <= r_rd_center;
        end
    end

    // The centre store is read one column ahead so that the right neighbour is ready.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_upper            <= r_upper_store[r_col];
            r_upper_store[r_col]  <= r_rd_center;
            r_rd_center           <= r_center_store[rd_addr];
            r_center_store[r_col] <= i_pixel;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_chan
        logic signed [CHANNEL_BITS:0]     gx;
        logic signed [CHANNEL_BITS:0]     gy;
        logic signed [2*CHANNEL_BITS+1:0] px;
        logic signed [2*CHANNEL_BITS+1:0] py;

        assign gx = $signed({1'b0, r_rd_center[k*CHANNEL_BITS +: CHANNEL_BITS]})
                  - $signed({1'b0, r_s1_left[k*CHANNEL_BITS +: CHANNEL_BITS]});
        assign gy = $signed({1'b0, r_s1_cur[k*CHANNEL_BITS +: CHANNEL_BITS]})
                  - $signed({1'b0, r_rd_upper[k*CHANNEL_BITS +: CHANNEL_BITS]});
        assign px = gx * gx;
        assign py = gy * gy;

        assign o_squares[(2*k)*SQW +: SQW]   = px[SQW-1:0];
        assign o_squares[(2*k+1)*SQW +: SQW] = py[SQW-1:0];
    end

endmodule

@@ design/getm_fifo.sv @@
// Short register queue that decouples the front end from the result stage.
// Depends on getm_pkg for its depth.
`timescale 1ns / 1ps

module getm_fifo
    import getm_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0]  r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ design/getm_back.sv @@
// Result stage: threshold compare, the extra last-row word and the output register.
// Depends on getm_pkg.
`timescale 1ns / 1ps

module getm_back
    import getm_pkg::*;
#(
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [THRESH_W-1:0]        i_threshold,
    input  logic                       i_q_valid,
    output logic                       o_q_pop,
    input  logic [12*CHANNEL_BITS-1:0] i_squares,
    input  t_item_flags                i_flags,
    input  logic                       i_m_tready,
    output logic                       o_m_tvalid,
    output logic [EDGE_BITS-1:0]       o_edges,
    output logic                       o_run_last,
    output logic                       o_frame_last
);

    localparam int SQW  = 2 * CHANNEL_BITS;
    localparam int SUMW = SQW + 1;
    localparam int CW   = (SUMW > THRESH_W) ? SUMW : THRESH_W;

    t_back_state r_state;
    t_back_state n_state;

    logic                 r_ovalid;
    logic [EDGE_BITS-1:0] r_edges;
    logic                 r_run_last;
    logic                 r_frame_last;
    logic                 r_trail_last_col;

    logic                 out_free;
    logic                 load;
    logic                 n_ovalid;
    logic [EDGE_BITS-1:0] n_edges;
    logic                 n_run_last;
    logic                 n_frame_last;
    logic [EDGE_BITS-1:0] over;

    for (genvar k = 0; k < EDGE_BITS; k++) begin : g_cmp
        logic [SUMW-1:0] sum;
        assign sum = {1'b0, i_squares[(2*k)*SQW +: SQW]}
                   + {1'b0, i_squares[(2*k+1)*SQW +: SQW]};
        assign over[k] = (CW'(sum) > CW'(i_threshold));
    end

    assign out_free = !r_ovalid || i_m_tready;
    assign o_q_pop  = out_free && (r_state == BK_PRIMARY) && i_q_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_PRIMARY: begin
                if (o_q_pop && i_flags.last_row) begin
                    n_state = BK_TRAILER;
                end
            end
            BK_TRAILER: begin
                if (out_free) begin
                    n_state = BK_PRIMARY;
                end
            end
            default: n_state = BK_PRIMARY;
        endcase
    end

    always_comb begin
        load         = 1'b0;
        n_ovalid     = 1'b0;
        n_edges      = '0;
        n_run_last   = 1'b0;
        n_frame_last = 1'b0;
        case (r_state)
            BK_PRIMARY: begin
                load       = out_free;
                n_ovalid   = i_q_valid;
                n_edges    = i_flags.border ? '0 : over;
                n_run_last = !i_flags.last_row;
            end
            BK_TRAILER: begin
                load         = out_free;
                n_ovalid     = 1'b1;
                n_run_last   = 1'b1;
                n_frame_last = r_trail_last_col;
            end
            default: load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_PRIMARY;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_ovalid <= n_ovalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_edges      <= n_edges;
            r_run_last   <= n_run_last;
            r_frame_last <= n_frame_last;
        end
        if (o_q_pop) begin
            r_trail_last_col <= i_flags.last_col;
        end
    end

    assign o_m_tvalid   = r_ovalid;
    assign o_edges      = r_edges;
    assign o_run_last   = r_run_last;
    assign o_frame_last = r_frame_last;

endmodule

@@ design/gradient_edge_threshold_map_unit.sv @@
// Top level of the gradient edge threshold map: configuration registers and wiring.
// Depends on getm_pkg, getm_front, getm_fifo and getm_back.
//
// Pixels enter on the slave stream in raster order, one word per pixel, and
// leave as edge words on the master stream. Each channel gets a central
// difference gradient; its edge bit is set when gx^2 + gy^2 exceeds the
// squared threshold. The result for a pixel leaves when the pixel below it
// arrives, so the first row yields no words and each later pixel one word.
// Pixels of the last row yield two words: the centre result and then the
// zero result of the last row itself; tuser marks the last word caused by a
// pixel and tlast the final word of the frame.
// A result passes through the input register, the queue and the output register.
// One pixel is taken per cycle until a full queue stalls the input; in the last row each
// pixel needs the single output register twice; a four-entry queue absorbs bursts.
// The configuration channel is always ready and should be written only while
// no pixel is in flight. Reset restores the default size and threshold and
// restarts at the top-left pixel; the line stores hold no reset value. When
// the receiver stalls, words back up through the queue into the input side.
`timescale 1ns / 1ps

module gradient_edge_threshold_map_unit
    import getm_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
    parameter int IN_TDATA_W   = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // pixel_red, pixel_green, pixel_blue from bit 0 up, zero padded
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // edge_red, edge_green, edge_blue from bit 0 up, zero padded
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tlast,
    // run_last
    output logic [0:0]             o_m_tuser
);

    localparam int SQ_BITS = 12 * CHANNEL_BITS;
    localparam int FLAG_W  = $bits(t_item_flags);
    localparam int Q_W     = SQ_BITS + FLAG_W;

    logic [LINE_WIDTH_W-1:0]   r_line_width;
    logic [FRAME_HEIGHT_W-1:0] r_frame_height;
    logic [THRESH_W-1:0]       r_threshold_sq;

    logic                 push;
    logic                 q_ready;
    logic [SQ_BITS-1:0]   front_squares;
    t_item_flags          front_flags;
    logic [Q_W-1:0]       q_out;
    logic                 q_valid;
    logic                 q_pop;
    t_item_flags          back_flags;
    logic [EDGE_BITS-1:0] edges;
    logic                 run_last;
    logic                 frame_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= RST_LINE_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_threshold_sq <= RST_THRESHOLD_SQ;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LINE_WIDTH:        r_line_width   <= i_cfg_data[LINE_WIDTH_W-1:0];
                CFG_FRAME_HEIGHT:      r_frame_height <= i_cfg_data[FRAME_HEIGHT_W-1:0];
                CFG_EDGE_THRESHOLD_SQ: r_threshold_sq <= i_cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    getm_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_line_width   (r_line_width),
        .i_frame_height (r_frame_height),
        .i_s_tvalid     (i_s_tvalid),
        .o_s_tready     (o_s_tready),
        .i_pixel        (i_s_tdata[3*CHANNEL_BITS-1:0]),
        .o_push         (push),
        .i_queue_ready  (q_ready),
        .o_squares      (front_squares),
        .o_flags        (front_flags)
    );

    getm_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .i_data  ({front_flags, front_squares}),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    assign back_flags = t_item_flags'(q_out[Q_W-1:SQ_BITS]);

    getm_back #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_threshold  (r_threshold_sq),
        .i_q_valid    (q_valid),
        .o_q_pop      (q_pop),
        .i_squares    (q_out[SQ_BITS-1:0]),
        .i_flags      (back_flags),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_edges      (edges),
        .o_run_last   (run_last),
        .o_frame_last (frame_last)
    );

    assign o_m_tdata = {{(OUT_TDATA_W-EDGE_BITS){1'b0}}, edges};
    assign o_m_tlast = frame_last;
    assign o_m_tuser = run_last;

endmodule

@@ design/getm_checker.sv @@
// Port-level checks on the result stream of the gradient edge threshold map.
// Depends on getm_pkg; bound to gradient_edge_threshold_map_unit below.
`timescale 1ns / 1ps

module getm_checker
    import getm_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic                   o_m_tlast,
    input logic [0:0]             o_m_tuser
);

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result word valid right after reset");

    a_stall_holds_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled result word changed");

    a_frame_end_is_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> (o_m_tdata[EDGE_BITS-1:0] == '0))
        else $error("final word of frame carries edge bits");

    a_frame_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser[0])
        else $error("final word of frame is not the last word of its pixel");

endmodule

bind gradient_edge_threshold_map_unit getm_checker u_getm_checker (.*);

@@ tb/sv/edge_map_check_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the gradient edge threshold map: predicts the edge words caused by each
// accepted pixel and checks the words leaving the block in order. Depends on getm_pkg.

package edge_map_check_pkg;
    import getm_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_WIDTH;

    typedef struct packed {
        logic [EDGE_BITS-1:0] edges;
        logic                 run_last;
        logic                 frame_last;
    } t_edge_word;

    class edge_map_scoreboard;
        logic [23:0]               upper_row [STORE_DEPTH];
        logic [23:0]               centre_row [STORE_DEPTH];
        logic [23:0]               left_centre;
        int unsigned               col;
        int unsigned               row;
        logic [LINE_WIDTH_W-1:0]   line_width;
        logic [FRAME_HEIGHT_W-1:0] frame_height;
        logic [THRESH_W-1:0]       threshold_sq;
        t_edge_word                edge_words_due [$];
        int                        mismatches;

        function new();
            foreach (upper_row[i]) begin
                upper_row[i]  = '0;
                centre_row[i] = '0;
            end
            left_centre  = '0;
            col          = 0;
            row          = 0;
            line_width   = RST_LINE_WIDTH;
            frame_height = RST_FRAME_HEIGHT;
            threshold_sq = RST_THRESHOLD_SQ;
            mismatches   = 0;
        endfunction

        function void write_register(t_cfg_index idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_LINE_WIDTH: begin
                    line_width = value[LINE_WIDTH_W-1:0];
                end
                CFG_FRAME_HEIGHT: begin
                    frame_height = value[FRAME_HEIGHT_W-1:0];
                end
                CFG_EDGE_THRESHOLD_SQ: begin
                    threshold_sq = value[THRESH_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void note_pixel(logic [23:0] px);
            int unsigned w;
            int unsigned h;
            int unsigned idx;
            int unsigned ridx;
            bit          last_col;
            bit          last_row;
            bit          border;
            int          gx;
            int          gy;
            int          ch;
            t_edge_word  word;
            w = (line_width < 3) ? 3 : (line_width > STORE_DEPTH) ? STORE_DEPTH : line_width;
            h = (frame_height < 3) ? 3 : (frame_height > MAX_HEIGHT) ? MAX_HEIGHT : frame_height;
            idx      = col % STORE_DEPTH;
            ridx     = (col + 1) % STORE_DEPTH;
            last_col = (col + 1 >= w);
            last_row = (row + 1 >= h);
            if (row >= 1) begin
                border = (row == 1) || (col == 0) || last_col;
                word   = '0;
                for (ch = 0; ch < 3; ch++) begin
                    gx = int'(centre_row[ridx][8*ch +: 8]) - int'(left_centre[8*ch +: 8]);
                    gy = int'(px[8*ch +: 8]) - int'(upper_row[idx][8*ch +: 8]);
                    word.edges[ch] = !border && (gx * gx + gy * gy > int'(threshold_sq));
                end
                word.run_last = !last_row;
                edge_words_due.push_back(word);
                // During the last row the row's own border word trails the centre word.
                if (last_row) begin
                    word            = '0;
                    word.run_last   = 1'b1;
                    word.frame_last = last_col;
                    edge_words_due.push_back(word);
                end
            end
            left_centre     = centre_row[idx];
            upper_row[idx]  = centre_row[idx];
            centre_row[idx] = px;
            if (last_col) begin
                col = 0;
                row = last_row ? 0 : row + 1;
            end else begin
                col = col + 1;
            end
        endfunction

        function void check_word(t_edge_word got);
            t_edge_word want;
            if (edge_words_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: edge word with none due: edges %b run_last %b frame_last %b",
                             $time, got.edges, got.run_last, got.frame_last);
                end
                return;
            end
            want = edge_words_due.pop_front();
            if (got.edges !== want.edges || got.run_last !== want.run_last ||
                got.frame_last !== want.frame_last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: edge word mismatch: expected edges %b run_last %b frame_last %b",
                             $time, want.edges, want.run_last, want.frame_last);
                    $display("%0t:                     actual   edges %b run_last %b frame_last %b",
                             $time, got.edges, got.run_last, got.frame_last);
                end
            end
        endfunction
    endclass

endpackage

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Regression top for gradient_edge_threshold_map_unit: clock, reset, pixel and edge streams,
// register writes and the stimulus phases. Depends on getm_pkg and edge_map_check_pkg.

module tb_top;
    import getm_pkg::*;
    import edge_map_check_pkg::*;

    localparam int CYCLE_LIMIT   = 800000;
    localparam int IDLE_PERCENT  = 34;
    localparam int SETTLE_CYCLES = 8;
    localparam int SQUEEZE_LEN   = 200;

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [23:0]            i_s_tdata   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;
    logic [0:0]             o_m_tuser;
    logic                   calm        = 1'b0;
    logic                   squeeze_req = 1'b0;

    edge_map_scoreboard sb = new();

    gradient_edge_threshold_map_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [23:0] pick_pixel(logic [23:0] base);
        logic [23:0] px;
        int          ch;
        int          v;
        if ($urandom_range(0, 99) < 40) begin
            return 24'($urandom);
        end
        for (ch = 0; ch < 3; ch++) begin
            v = int'(base[8*ch +: 8]) + int'($urandom_range(0, 40)) - 20;
            px[8*ch +: 8] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
        end
        return px;
    endfunction

    task automatic write_register(input t_cfg_index idx, input int unsigned value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_register(idx, CFG_DATA_W'(value));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned w, input int unsigned h, input int unsigned thr);
        write_register(CFG_LINE_WIDTH, w);
        write_register(CFG_FRAME_HEIGHT, h);
        write_register(CFG_EDGE_THRESHOLD_SQ, thr);
    endtask

    task automatic send_pixel(input logic [23:0] px);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= px;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_pixel(px);
    endtask

    // Sends pixels until the frame in progress is complete, always at least one.
    task automatic finish_frame();
        logic [23:0] base;
        base = 24'($urandom);
        do begin
            send_pixel(pick_pixel(base));
        end while (sb.col != 0 || sb.row != 0);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.edge_words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : edge_receiver
        int         hold_left;
        bit         hold_done;
        t_edge_word got;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got.edges      = o_m_tdata[EDGE_BITS-1:0];
                got.run_last   = o_m_tuser[0];
                got.frame_last = o_m_tlast;
                sb.check_word(got);
            end
            if (squeeze_req && !hold_done) begin
                hold_left = SQUEEZE_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("gradient_edge_threshold_map_unit regression: fail");
        $finish;
    end

    initial begin : stimulus
        logic [23:0] first_frames [18];
        int          phase;
        int          i;
        int unsigned w;
        int unsigned h;
        int unsigned thr;
        first_frames = '{
            24'h000000, 24'h563412, 24'hFFFFFF,
            24'hFF00FF, 24'h808080, 24'h00FF00,
            24'hFF0000, 24'hBADCFE, 24'h010101,
            24'h000000, 24'hFFFFFF, 24'h000000,
            24'h000000, 24'h5A5A5A, 24'h00FFFF,
            24'hFFFFFF, 24'h000000, 24'hFFFFFF
        };
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Width and height below range clamp to 3; any nonzero gradient beats a zero threshold.
        configure(0, 2, 0);
        for (i = 0; i < 9; i++) send_pixel(first_frames[i]);
        drain();
        // The threshold sits just below the largest possible sum, so only full-scale steps exceed it.
        configure(3, 3, 130049);
        for (i = 9; i < 18; i++) send_pixel(first_frames[i]);
        drain();

        for (phase = 0; phase < 9; phase++) begin
            case (phase)
                0: thr = 4064;
                1: thr = 131071;
                2: thr = 130050;
                3: thr = 1;
                default: thr = $urandom_range(0, 20000);
            endcase
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            if (phase == 5) begin
                w = 12;
                h = 6;
            end
            configure(w, h, thr);
            if (phase == 2) begin
                calm <= 1'b1;
            end
            if (phase == 5) begin
                squeeze_req <= 1'b1;
            end
            repeat ((phase == 5) ? 2 : 1) finish_frame();
            drain();
            calm <= 1'b0;
        end

        // Frame height lowered below the current row: that row becomes the last one.
        configure(5, 8191, 3000);
        for (i = 0; i < 20; i++) send_pixel(24'($urandom));
        drain();
        write_register(CFG_FRAME_HEIGHT, 1);
        finish_frame();
        drain();

        // Line width lowered below the current column: the next pixel ends the row.
        configure(9, 4, 1500);
        for (i = 0; i < 14; i++) send_pixel(24'($urandom));
        drain();
        write_register(CFG_LINE_WIDTH, 2);
        finish_frame();
        drain();

        if (sb.mismatches == 0 && sb.edge_words_due.size() == 0) begin
            $display("gradient_edge_threshold_map_unit regression: pass");
        end else begin
            $display("gradient_edge_threshold_map_unit regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/getm_pkg.sv
design/getm_front.sv
design/getm_fifo.sv
design/getm_back.sv
design/gradient_edge_threshold_map_unit.sv
design/getm_checker.sv
tb/sv/edge_map_check_pkg.sv
tb/sv/tb_top.sv
